// File: rtl/core/pss_pkg.sv
package pss_pkg;

   localparam int DIGITS_DEF = 4;
   localparam int PAGES_DEF = 8;

   localparam logic [2:0] OP_SCAN = 3'd0;
   localparam logic [2:0] OP_HEX = 3'd1;
   localparam logic [2:0] OP_DIGIT = 3'd2;
   localparam logic [2:0] OP_SHIFT = 3'd3;
   localparam logic [2:0] OP_ENABLE = 3'd4;

   localparam logic [7:0] SEG_BLANK = 8'hFF;
   localparam logic [3:0] COM_IDLE = 4'hF;
   localparam logic [3:0] COM_FIRST = 4'h8;
   localparam int COM_BITS = 4;

   typedef struct packed {
      logic [2:0] operation;
      logic [2:0] page;
      logic [1:0] digit;
      logic [15:0] value;
      logic [7:0] segments;
      logic use_font;
      logic blank_leading;
      logic force_zero;
      logic clear_first;
      logic enable;
   } req_type;

   typedef struct packed {
      logic [7:0] segment_drive;
      logic [3:0] common_drive;
      logic [2:0] shown_page;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic read;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_scan;
   } dp_status_type;

   // Hex glyphs in gfedcba order, returned inverted for active-low segments.
   function automatic logic [7:0] font_low(input logic [3:0] nib);
      logic [7:0] glyph;
      case (nib)
         4'h0: glyph = 8'h3F;
         4'h1: glyph = 8'h06;
         4'h2: glyph = 8'h5B;
         4'h3: glyph = 8'h4F;
         4'h4: glyph = 8'h66;
         4'h5: glyph = 8'h6D;
         4'h6: glyph = 8'h7D;
         4'h7: glyph = 8'h07;
         4'h8: glyph = 8'h7F;
         4'h9: glyph = 8'h6F;
         4'hA: glyph = 8'h77;
         4'hB: glyph = 8'h7C;
         4'hC: glyph = 8'h39;
         4'hD: glyph = 8'h5E;
         4'hE: glyph = 8'h79;
         4'hF: glyph = 8'h71;
         default: glyph = 8'h00;
      endcase
      return ~glyph;
   endfunction

endpackage

// File: rtl/core/pss_ctrl.sv
module pss_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  pss_pkg::dp_status_type status,
   output pss_pkg::ctrl_cmd_type cmd
);
   import pss_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic can_commit;

   // A scan result may only be committed when the output register is free
   // or is being drained in this very cycle.
   assign can_commit = !status.is_scan || !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (can_commit) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit && status.is_scan) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/pss_datapath.sv
module pss_datapath #(
   parameter int DIGITS = pss_pkg::DIGITS_DEF,
   parameter int PAGES = pss_pkg::PAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  pss_pkg::req_type req_data,
   output pss_pkg::rsp_type rsp_data,
   input  pss_pkg::ctrl_cmd_type cmd,
   output pss_pkg::dp_status_type status
);
   import pss_pkg::*;

   localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int PAGE_W = $clog2(PAGES);
   localparam int ROW_W = DIGITS * 8;

   req_type item_ff;
   rsp_type rsp_ff;
   logic [ROW_W-1:0] store_mem [PAGES];
   logic [ROW_W-1:0] rd_row_ff;
   logic rd_ok_ff;
   logic [PAGES-1:0] row_valid_ff;
   logic [PAGES-1:0] page_used_ff, page_used_in;
   logic [PAGE_W-1:0] display_page_ff, display_page_in;
   logic [DIG_W-1:0] scan_ff;
   logic top_latch_ff;

   logic is_scan;
   logic page_ok;
   logic digit_ok;
   logic writes_row;
   logic mem_we;
   logic [PAGE_W-1:0] item_page;
   logic [PAGE_W-1:0] row_addr;
   logic [ROW_W-1:0] row_cur;
   logic [ROW_W-1:0] row_new;
   logic [ROW_W-1:0] hex_row;
   logic [ROW_W-1:0] digit_row;
   logic [ROW_W-1:0] shift_row;
   logic [7:0] pat;
   logic [7:0] drive;
   logic [3:0] com;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   assign is_scan = (item_ff.operation == OP_SCAN);
   assign page_ok = (32'(item_ff.page) < PAGES);
   assign digit_ok = (32'(item_ff.digit) < DIGITS);
   assign item_page = PAGE_W'(item_ff.page);
   assign row_addr = is_scan ? display_page_ff : item_page;
   assign status.is_scan = is_scan;

   always_comb begin
      case (item_ff.operation)
         OP_HEX: writes_row = 1'b1;
         OP_DIGIT: writes_row = digit_ok;
         OP_SHIFT: writes_row = 1'b1;
         default: writes_row = 1'b0;
      endcase
   end

   assign mem_we = cmd.commit && page_ok && writes_row;

   // One row holds all digits of a page.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[row_addr] <= row_new;
      end
      if (cmd.read) begin
         rd_row_ff <= store_mem[row_addr];
         rd_ok_ff <= row_valid_ff[row_addr];
      end
   end

   // A row never written since reset reads as all zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (mem_we) begin
         row_valid_ff[row_addr] <= 1'b1;
      end
   end

   assign row_cur = rd_ok_ff ? rd_row_ff : '0;

   always_comb begin
      logic seen;
      logic [3:0] nib;
      seen = 1'b0;
      hex_row = '0;
      for (int p = DIGITS - 1; p >= 0; p--) begin
         nib = 4'(item_ff.value >> (4 * p));
         if (nib == 4'h0 && !seen && item_ff.blank_leading) begin
            hex_row[8*p +: 8] = SEG_BLANK;
         end else begin
            hex_row[8*p +: 8] = font_low(nib);
            if (nib != 4'h0) begin
               seen = 1'b1;
            end
         end
      end
      if (item_ff.value == 16'h0000 && item_ff.force_zero) begin
         hex_row[7:0] = font_low(4'h0);
      end
   end

   always_comb begin
      digit_row = row_cur;
      digit_row[8*DIG_W'(item_ff.digit) +: 8] =
         item_ff.use_font ? font_low(item_ff.value[3:0]) : item_ff.segments;
   end

   always_comb begin
      shift_row = '0;
      for (int k = 1; k < DIGITS; k++) begin
         shift_row[8*k +: 8] = item_ff.clear_first ? SEG_BLANK : row_cur[8*(k-1) +: 8];
      end
      shift_row[7:0] = item_ff.segments;
   end

   always_comb begin
      case (item_ff.operation)
         OP_HEX: row_new = hex_row;
         OP_DIGIT: row_new = digit_row;
         OP_SHIFT: row_new = shift_row;
         default: row_new = row_cur;
      endcase
   end

   always_comb begin
      page_used_in = page_used_ff;
      if (cmd.commit && page_ok) begin
         if (item_ff.operation == OP_ENABLE) begin
            page_used_in[item_page] = item_ff.enable;
         end else if (writes_row) begin
            page_used_in[item_page] = 1'b1;
         end
      end
   end

   // Highest page in use wins; with no page in use the old choice stays.
   always_comb begin
      display_page_in = display_page_ff;
      for (int p = 0; p < PAGES; p++) begin
         if (page_used_in[p]) begin
            display_page_in = PAGE_W'(p);
         end
      end
   end

   assign pat = row_cur[8*scan_ff +: 8];
   assign drive = {pat[7] & top_latch_ff, pat[6:0]};

   always_comb begin
      if (32'(scan_ff) < COM_BITS) begin
         com = COM_IDLE & ~(COM_FIRST >> scan_ff);
      end else begin
         com = COM_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_used_ff <= PAGES'(1);
         display_page_ff <= '0;
         scan_ff <= '0;
         top_latch_ff <= 1'b1;
      end else if (cmd.commit) begin
         page_used_ff <= page_used_in;
         display_page_ff <= display_page_in;
         if (is_scan) begin
            top_latch_ff <= drive[7];
            if (32'(scan_ff) >= DIGITS - 1) begin
               scan_ff <= '0;
            end else begin
               scan_ff <= scan_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && is_scan) begin
         rsp_ff.segment_drive <= drive;
         rsp_ff.common_drive <= com;
         rsp_ff.shown_page <= 3'(display_page_ff);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/core/paged_seven_segment_scanner.sv
// The transfer captures an item, the read state then reads the page row and the execute state
// writes it or scans it; a scan result is registered when execute commits. Items are worked
// one at a time: a new item is taken only after the last has left execute, as the single-port
// page memory is read and then written or scanned by one sequencer.
// A scan result sits in an output register; a new item is taken while it waits, but a scan
// holds in execute until that earlier result is transferred. Synchronous active-high reset:
// page 0 in use and shown, scan index zero, all digit patterns read as zero until written.
module paged_seven_segment_scanner #(
   parameter int DIGITS = pss_pkg::DIGITS_DEF,
   parameter int PAGES = pss_pkg::PAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  pss_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output pss_pkg::rsp_type rsp_data
);
   import pss_pkg::*;

   ctrl_cmd_type cmd;
   dp_status_type status;

   pss_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status(status),
      .cmd(cmd)
   );

   pss_datapath #(
      .DIGITS(DIGITS),
      .PAGES(PAGES)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .rsp_data(rsp_data),
      .cmd(cmd),
      .status(status)
   );

endmodule

// File: rtl/core/pss_checker.sv
module pss_checker #(
   parameter int DIGITS = pss_pkg::DIGITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input pss_pkg::rsp_type rsp_data
);
   import pss_pkg::*;

   // A waiting result must hold until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Items are worked one at a time, so a transfer closes the input side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in work");

   // With four or fewer digits every scan pulls exactly one common low.
   a_one_common: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (DIGITS <= COM_BITS) |-> $countones(rsp_data.common_drive) == 3)
      else $error("common drive does not select one digit");

   // Leaving reset the block is empty and ready.
   a_reset_state: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind paged_seven_segment_scanner pss_checker #(
   .DIGITS(DIGITS)
) u_checker (.*);

// File: test/paged_seven_segment_scanner_tb.sv
module paged_seven_segment_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam int N_PAGES = PAGES_DEF;
   localparam int N_DIGITS = DIGITS_DEF;
   localparam int RANDOM_PER_PHASE = 320;

   // Hex glyphs 0..F in gfedcba order, glyph n in byte n.
   localparam logic [127:0] HEX_FONT = {
      8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
      8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   paged_seven_segment_scanner uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Display state as the block should hold it.
   logic [7:0] page_digits [N_PAGES][N_DIGITS];
   logic [N_PAGES-1:0] pages_in_use = N_PAGES'(1);
   logic [2:0] shown = '0;
   logic [1:0] scan_pos = '0;
   logic dp_latch = 1'b1;

   req_type pending_requests[$];
   rsp_type expected_scans[$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int items_taken = 0;
   int scans_checked = 0;
   int error_count = 0;

   initial begin
      for (int p = 0; p < N_PAGES; p++) begin
         for (int d = 0; d < N_DIGITS; d++) begin
            page_digits[p][d] = 8'h00;
         end
      end
   end

   function automatic logic [7:0] inverted_glyph(input logic [3:0] nib);
      return ~HEX_FONT[nib*8 +: 8];
   endfunction

   task automatic advance_display_model(input req_type r);
      rsp_type scan;
      logic [7:0] pattern;
      logic [3:0] nib;
      logic seen;
      logic found;
      logic page_changed;
      page_changed = 1'b1;
      case (r.operation)
         OP_SCAN: begin
            pattern = page_digits[shown][scan_pos];
            scan.segment_drive = {pattern[7] & dp_latch, pattern[6:0]};
            dp_latch = scan.segment_drive[7];
            scan.common_drive = COM_IDLE & ~(COM_FIRST >> scan_pos);
            scan.shown_page = shown;
            expected_scans.push_back(scan);
            scan_pos = (scan_pos == N_DIGITS - 1) ? 2'd0 : scan_pos + 2'd1;
            page_changed = 1'b0;
         end
         OP_HEX: begin
            seen = 1'b0;
            for (int p = N_DIGITS - 1; p >= 0; p--) begin
               nib = r.value[4*p +: 4];
               if (nib == 4'h0 && !seen && r.blank_leading) begin
                  page_digits[r.page][p] = SEG_BLANK;
               end else begin
                  page_digits[r.page][p] = inverted_glyph(nib);
                  if (nib != 4'h0) seen = 1'b1;
               end
            end
            if (r.value == 16'h0000 && r.force_zero) begin
               page_digits[r.page][0] = inverted_glyph(4'h0);
            end
            pages_in_use[r.page] = 1'b1;
         end
         OP_DIGIT: begin
            page_digits[r.page][r.digit] =
               r.use_font ? inverted_glyph(r.value[3:0]) : r.segments;
            pages_in_use[r.page] = 1'b1;
         end
         OP_SHIFT: begin
            if (r.clear_first) begin
               for (int d = 0; d < N_DIGITS; d++) page_digits[r.page][d] = SEG_BLANK;
            end
            for (int d = N_DIGITS - 1; d > 0; d--) begin
               page_digits[r.page][d] = page_digits[r.page][d-1];
            end
            page_digits[r.page][0] = r.segments;
            pages_in_use[r.page] = 1'b1;
         end
         OP_ENABLE: begin
            pages_in_use[r.page] = r.enable;
         end
         default: begin
            page_changed = 1'b0;
         end
      endcase
      // With no page in use the display stays on the page it had.
      if (page_changed) begin
         found = 1'b0;
         for (int p = N_PAGES - 1; p >= 0; p--) begin
            if (pages_in_use[p] && !found) begin
               shown = 3'(p);
               found = 1'b1;
            end
         end
      end
   endtask

   task automatic push_req(input logic [2:0] op, input logic [2:0] pg, input logic [1:0] dg,
                           input logic [15:0] val, input logic [7:0] seg,
                           input logic [4:0] flags);
      req_type r;
      r.operation = op;
      r.page = pg;
      r.digit = dg;
      r.value = val;
      r.segments = seg;
      {r.use_font, r.blank_leading, r.force_zero, r.clear_first, r.enable} = flags;
      pending_requests.push_back(r);
   endtask

   function automatic req_type random_request();
      req_type r;
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) r.operation = OP_SCAN;
      else if (roll < 60) r.operation = OP_HEX;
      else if (roll < 75) r.operation = OP_DIGIT;
      else if (roll < 88) r.operation = OP_SHIFT;
      else if (roll < 97) r.operation = OP_ENABLE;
      else r.operation = 3'($urandom_range(7, 5));
      r.page = 3'($urandom_range(N_PAGES - 1));
      r.digit = 2'($urandom_range(N_DIGITS - 1));
      // Shifted values give leading zero nibbles for the blanking logic.
      r.value = 16'($urandom);
      if ($urandom_range(1)) r.value = r.value >> $urandom_range(16, 1);
      r.segments = 8'($urandom);
      r.use_font = 1'($urandom_range(1));
      r.blank_leading = 1'($urandom_range(1));
      r.force_zero = 1'($urandom_range(1));
      r.clear_first = 1'($urandom_range(1));
      r.enable = 1'($urandom_range(1));
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_display_model(req_data);
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scans.size() == 0) begin
               $error("scan result with none pending: %h", rsp_data);
               error_count++;
            end else begin
               want = expected_scans.pop_front();
               scans_checked++;
               if (rsp_data.segment_drive !== want.segment_drive) begin
                  $error("segment_drive: expected %h, got %h",
                         want.segment_drive, rsp_data.segment_drive);
                  error_count++;
               end
               if (rsp_data.common_drive !== want.common_drive) begin
                  $error("common_drive: expected %h, got %h",
                         want.common_drive, rsp_data.common_drive);
                  error_count++;
               end
               if (rsp_data.shown_page !== want.shown_page) begin
                  $error("shown_page: expected %0d, got %0d",
                         want.shown_page, rsp_data.shown_page);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 72; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 72; end
            default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
         endcase
         if (ph == 0) begin
            // Blank page 0 so the decimal point shows high before it latches low.
            push_req(OP_SHIFT, 3'd0, 2'd0, 16'h0000, 8'hFF, 5'b00010);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_DIGIT, 3'd0, 2'd1, 16'hFFFA, 8'h00, 5'b10000);
            push_req(OP_DIGIT, 3'd0, 2'd3, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_HEX, 3'd5, 2'd0, 16'h0000, 8'h00, 5'b01100);
            push_req(OP_HEX, 3'd6, 2'd0, 16'h00F0, 8'h00, 5'b01000);
            push_req(OP_HEX, 3'd7, 2'd0, 16'hFFFF, 8'h00, 5'b00000);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_ENABLE, 3'd7, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_SHIFT, 3'd6, 2'd0, 16'h0000, 8'h55, 5'b00010);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_HEX, 3'd3, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(3'd5, 3'd7, 2'd3, 16'hFFFF, 8'hFF, 5'b11111);
            push_req(3'd6, 3'd7, 2'd3, 16'hFFFF, 8'hFF, 5'b11111);
            push_req(3'd7, 3'd7, 2'd3, 16'hFFFF, 8'hFF, 5'b11111);
            // Turning every page off leaves the display where it was.
            push_req(OP_ENABLE, 3'd6, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_ENABLE, 3'd5, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_ENABLE, 3'd3, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_ENABLE, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_ENABLE, 3'd2, 2'd0, 16'h0000, 8'h00, 5'b00001);
            push_req(OP_SCAN, 3'd0, 2'd0, 16'h0000, 8'h00, 5'b00000);
            push_req(OP_HEX, 3'd1, 2'd0, 16'h1234, 8'h00, 5'b00100);
         end
         repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
         // Sampled away from the rising edge so the driver's updates have settled.
         while (pending_requests.size() != 0 || req_valid || expected_scans.size() != 0) begin
            @(negedge clock);
         end
      end
      // Wait on to catch any stray scan result.
      repeat (10) @(posedge clock);
      $display("Sent %0d requests over four handshake phases; checked %0d scan results.",
               items_taken, scans_checked);
      if (error_count == 0) begin
         $display("paged_seven_segment_scanner: match");
      end else begin
         $display("paged_seven_segment_scanner: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d scan results outstanding.", expected_scans.size());
      $display("paged_seven_segment_scanner: mismatch");
      $finish;
   end

endmodule
